>>> rtl/core/diffusion_reaction_stencil_step_macros.svh
// Assertion macros used by the checker file of the stencil step block.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef DIFFUSION_REACTION_STENCIL_STEP_MACROS_SVH
`define DIFFUSION_REACTION_STENCIL_STEP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DFRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dfrs: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DFRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dfrs: assertion failed");

`endif

>>> rtl/core/dfrs_pkg.sv
// Types and constants of the diffusion-reaction stencil step block.
// No dependencies; used by the top level and the checker.
package dfrs_pkg;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  localparam logic [1:0] CFG_DIFF_GAIN = 2'd0;
  localparam logic [1:0] CFG_REACT_RATE = 2'd1;
  localparam logic [1:0] CFG_CAP_LEVEL = 2'd2;
  localparam logic [1:0] CFG_NUM_CELLS = 2'd3;

  localparam logic [15:0] DIFF_GAIN_RST = 16'd52;
  localparam logic [15:0] REACT_RATE_RST = 16'd3277;
  localparam logic signed [15:0] CAP_LEVEL_RST = 16'sd4915;
  localparam logic [4:0] NUM_CELLS_RST = 5'd10;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef struct packed {
    logic               req_type;
    logic [3:0]         cell_index;
    logic signed [15:0] load_value;
  } req_t;

  typedef struct packed {
    logic [3:0]         cell_index_res;
    logic signed [15:0] level;
    logic               last;
  } res_t;

endpackage

>>> rtl/core/dfrs_cell_mem.sv
// Row store of the stencil step: one write port, one registered read port.
// Per-entry valid bits make never-written cells read as zero after reset.
module dfrs_cell_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic signed [15:0]      wdata_i,
  input  logic [AddrW-1:0]        raddr_i,
  output logic signed [15:0]      rdata_o
);

  logic signed [15:0] mem [Depth];
  logic [Depth-1:0]   vld_q;
  logic signed [15:0] rd_data_q;
  logic               rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_data_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  // Cells never written since reset hold zero.
  assign rdata_o = rd_vld_q ? rd_data_q : 16'sd0;

endmodule

>>> rtl/core/diffusion_reaction_stencil_step.sv
// Top level of the diffusion-reaction stencil step: sequencer, shared multiplier.
// Depends on dfrs_pkg and dfrs_cell_mem.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------
//   request  | start_i, busy_o         | req_i  (req_type, cell_index, value)
//   result   | res_strobe_o            | res_o  (cell_index_res, level, last)
//   config   | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// A load request writes the store directly and leaves busy_o low.
// A step request holds busy_o high while it primes the neighbor window, then,
// for each of the n cells in use, runs fetch, three passes through the one
// shared multiplier, and the sum with write-back.
// Each result leaves in the cycle after its write-back; the receiver cannot stall.
// Reset restores control state and register defaults and clears the store's valid bits.
module diffusion_reaction_stencil_step #(
  parameter int unsigned MAX_CELLS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  dfrs_pkg::req_t                      req_i,
  output logic                                res_strobe_o,
  output dfrs_pkg::res_t                      res_o,
  input  logic                                cfg_we_i,
  input  logic [dfrs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dfrs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import dfrs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_CELLS);
  localparam int unsigned RowLimit = (MAX_CELLS < 16) ? MAX_CELLS : 16;
  localparam logic [4:0] RowLimitC = 5'(RowLimit);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRIME = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_MUL_D = 3'd3;
  localparam logic [2:0] ST_MUL_T = 3'd4;
  localparam logic [2:0] ST_MUL_R = 3'd5;
  localparam logic [2:0] ST_SUM   = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [15:0]        dgain_q, rgain_q;
  logic signed [15:0] cap_q;
  logic [4:0]         ncfg_q;
  logic [4:0]         n_q, n_d;
  logic [3:0]         idx_q;
  logic [4:0]         idx_p1, idx_p2;
  logic               res_strobe_q;
  res_t               res_q;

  logic signed [15:0] prev_q, cur_q, nxt_q;
  logic signed [18:0] lap_q;
  logic signed [16:0] diff_q;
  logic signed [21:0] dterm_q;
  logic signed [37:0] prod_q;

  logic signed [16:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [37:0] mul_p;

  logic               accept, load_acc, step_acc;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic signed [15:0] mem_wdata, mem_rdata;
  logic signed [15:0] nxt_val;
  logic signed [23:0] sum_full;
  logic signed [15:0] sum_sat, fresh;
  logic               is_last;

  assign accept   = start_i && !busy_o;
  assign load_acc = accept && (req_i.req_type == REQ_LOAD);
  assign step_acc = accept && (req_i.req_type == REQ_STEP);
  assign busy_o   = (state_q != ST_IDLE);

  assign idx_p1  = {1'b0, idx_q} + 5'd1;
  assign idx_p2  = {1'b0, idx_q} + 5'd2;
  assign is_last = (idx_p1 == n_q);

  // Clamp the configured row length to one..row limit.
  always_comb begin
    if (ncfg_q == 5'd0) begin
      n_d = 5'd1;
    end else if (ncfg_q > RowLimitC) begin
      n_d = RowLimitC;
    end else begin
      n_d = ncfg_q;
    end
  end

  // Shared multiplier: diffusion, logistic product, reaction scaling.
  always_comb begin
    unique case (state_q)
      ST_MUL_D: begin
        mul_a = {1'b0, dgain_q};
        mul_b = {{2{lap_q[18]}}, lap_q};
      end
      ST_MUL_T: begin
        mul_a = {cur_q[15], cur_q};
        mul_b = {{4{diff_q[16]}}, diff_q};
      end
      ST_MUL_R: begin
        mul_a = {1'b0, rgain_q};
        mul_b = prod_q[32:12];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign nxt_val = (idx_p1 < n_q) ? mem_rdata : 16'sd0;

  assign sum_full = {{8{cur_q[15]}}, cur_q} + {{2{dterm_q[21]}}, dterm_q}
                  + {{2{prod_q[37]}}, prod_q[37:16]};

  always_comb begin
    if (sum_full > 24'sd32767) begin
      sum_sat = 16'sh7fff;
    end else if (sum_full < -24'sd32768) begin
      sum_sat = 16'sh8000;
    end else begin
      sum_sat = sum_full[15:0];
    end
  end

  // Hold a cell that sits exactly at the cap.
  assign fresh = (cur_q == cap_q) ? cur_q : sum_sat;

  // Row store ports.
  always_comb begin
    unique case (state_q)
      ST_IDLE:  mem_raddr = '0;
      ST_PRIME: mem_raddr = AW'(1);
      ST_SUM:   mem_raddr = AW'(idx_p2);
      default:  mem_raddr = '0;
    endcase
  end

  always_comb begin
    if (state_q == ST_SUM) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(idx_q);
      mem_wdata = fresh;
    end else begin
      mem_we    = load_acc && (32'(req_i.cell_index) < MAX_CELLS);
      mem_waddr = AW'(req_i.cell_index);
      mem_wdata = req_i.load_value;
    end
  end

  dfrs_cell_mem #(
    .Depth (MAX_CELLS),
    .AddrW (AW)
  ) u_cell_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (step_acc) begin
        state_d = ST_PRIME;
      end
      ST_PRIME: state_d = ST_FETCH;
      ST_FETCH: state_d = ST_MUL_D;
      ST_MUL_D: state_d = ST_MUL_T;
      ST_MUL_T: state_d = ST_MUL_R;
      ST_MUL_R: state_d = ST_SUM;
      ST_SUM:   state_d = is_last ? ST_IDLE : ST_FETCH;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      res_strobe_q <= 1'b0;
      idx_q        <= '0;
      n_q          <= 5'd1;
      dgain_q      <= DIFF_GAIN_RST;
      rgain_q      <= REACT_RATE_RST;
      cap_q        <= CAP_LEVEL_RST;
      ncfg_q       <= NUM_CELLS_RST;
    end else begin
      state_q      <= state_d;
      res_strobe_q <= (state_q == ST_SUM);
      if (step_acc) begin
        idx_q <= '0;
        n_q   <= n_d;
      end else if ((state_q == ST_SUM) && !is_last) begin
        idx_q <= idx_p1[3:0];
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DIFF_GAIN:  dgain_q <= cfg_data_i;
          CFG_REACT_RATE: rgain_q <= cfg_data_i;
          CFG_CAP_LEVEL:  cap_q   <= cfg_data_i;
          CFG_NUM_CELLS:  ncfg_q  <= cfg_data_i[4:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath: neighbor window, term registers, result register.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        prev_q <= 16'sd0;
      end
      ST_PRIME: begin
        cur_q <= mem_rdata;
      end
      ST_FETCH: begin
        nxt_q  <= nxt_val;
        lap_q  <= {{3{prev_q[15]}}, prev_q} + {{3{nxt_val[15]}}, nxt_val}
                - {{2{cur_q[15]}}, cur_q, 1'b0};
        diff_q <= {cap_q[15], cap_q} - {cur_q[15], cur_q};
      end
      ST_MUL_D: begin
        prod_q <= mul_p;
      end
      ST_MUL_T: begin
        dterm_q <= prod_q[37:16];
        prod_q  <= mul_p;
      end
      ST_MUL_R: begin
        prod_q <= mul_p;
      end
      ST_SUM: begin
        res_q.cell_index_res <= idx_q;
        res_q.level          <= fresh;
        res_q.last           <= is_last;
        // Slide the window: the old value of this cell becomes the left one.
        prev_q <= cur_q;
        cur_q  <= nxt_q;
      end
      default: ;
    endcase
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

>>> rtl/core/dfrs_checker.sv
// Port-level checker for the stencil step block, bound to the top level.
// Depends on dfrs_pkg and diffusion_reaction_stencil_step_macros.svh.
`include "diffusion_reaction_stencil_step_macros.svh"

module dfrs_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  dfrs_pkg::req_t req_i,
  input  logic           res_strobe_i,
  input  dfrs_pkg::res_t res_i
);
  import dfrs_pkg::*;

  // A step request occupies the block; a load request does not.
  `DFRS_ASSERT_NEXT(a_step_goes_busy, clk_i, rst_ni, start_i && !busy_i && (req_i.req_type == REQ_STEP), busy_i)
  `DFRS_ASSERT_NEXT(a_load_stays_idle, clk_i, rst_ni, start_i && !busy_i && (req_i.req_type == REQ_LOAD), !busy_i)
  // Results only follow a busy cycle.
  `DFRS_ASSERT_IMPL(a_res_after_busy, clk_i, rst_ni, res_strobe_i, $past(busy_i))
  // The final result of a run coincides with the return to idle.
  `DFRS_ASSERT_IMPL(a_last_ends_run, clk_i, rst_ni, res_strobe_i && res_i.last, !busy_i)
  `DFRS_ASSERT_IMPL(a_mid_run_busy, clk_i, rst_ni, res_strobe_i && !res_i.last, busy_i)

endmodule

bind diffusion_reaction_stencil_step dfrs_checker u_dfrs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_i       (busy_o),
  .req_i        (req_i),
  .res_strobe_i (res_strobe_o),
  .res_i        (res_o)
);
